// File: rtl/bmp24_pkg.sv
// ----------------------------------------------------------------------------
// bmp24_pkg
// Shared types and constants for the 24-bit bitmap pixel stream reader.
// ----------------------------------------------------------------------------
package bmp24_pkg;

  // Largest accepted image width or height, and the counter width it needs.
  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);

  // Header layout.
  localparam int HDR_LEN  = 54;
  localparam int OFS_POS  = 10;
  localparam int WID_POS  = 18;
  localparam int HGT_POS  = 22;
  localparam int DEP_POS  = 28;
  localparam int DEPTH_24 = 24;

  // Gray and black/white conversion.
  localparam int BW_THRESH  = 127;
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;

  // Configuration register indexes.
  localparam int REG_PIXEL_MODE = 0;

  typedef enum logic [1:0] {
    MODE_COLOR = 2'd0,
    MODE_GRAY  = 2'd1,
    MODE_BW    = 2'd2,
    MODE_BW_ALT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_PIXEL     = 2'd0,
    ST_BAD_DEPTH = 2'd1,
    ST_TOO_LARGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SKIP   = 2'd1,
    PH_PIXELS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  // Converted pixel components.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] level;
  } pixel_out_t;

endpackage

// File: rtl/bmp24_pixel_conv.sv
// ----------------------------------------------------------------------------
// bmp24_pixel_conv
// Turns one blue, green, red triple into colour, gray or black/white output.
// ----------------------------------------------------------------------------
module bmp24_pixel_conv (
  input  bmp24_pkg::mode_t      mode,
  input  logic [7:0]            red_in,
  input  logic [7:0]            green_in,
  input  logic [7:0]            blue_in,
  output bmp24_pkg::pixel_out_t pixel
);

  logic [9:0]  sum;
  logic [19:0] scaled;
  logic [7:0]  gray;

  // Division by three as a multiply by 683/2048; exact for sums up to 765.
  assign sum    = 10'(red_in) + 10'(green_in) + 10'(blue_in);
  assign scaled = 20'(sum) * 20'(bmp24_pkg::DIV3_MUL);
  assign gray   = scaled[bmp24_pkg::DIV3_SHIFT +: 8];

  always_comb begin
    pixel = '0;
    unique case (mode)
      bmp24_pkg::MODE_COLOR: begin
        pixel.red   = red_in;
        pixel.green = green_in;
        pixel.blue  = blue_in;
      end
      bmp24_pkg::MODE_GRAY: begin
        pixel.level = gray;
      end
      bmp24_pkg::MODE_BW, bmp24_pkg::MODE_BW_ALT: begin
        pixel.level = (gray > 8'(bmp24_pkg::BW_THRESH)) ? 8'd1 : 8'd0;
      end
      default: begin
        pixel = '0;
      end
    endcase
  end

endmodule

// File: rtl/bmp24_pixel_stream_reader.sv
// ----------------------------------------------------------------------------
// bmp24_pixel_stream_reader
// Byte-serial reader for 24-bit bitmap files with flipped-row pixel output.
// ----------------------------------------------------------------------------
// Usage:
// The byte channel (byte_valid, byte_stall, data_byte, file_start) carries one
// file byte per beat; file_start marks byte 0 of a new file and restarts the
// parse. The pixel channel (pixel_valid, pixel_stall and the result fields)
// carries one beat per pixel, plus one error beat when the header names a
// depth other than 24 or a dimension above MAX_DIM.
// Throughput is one byte per cycle. A result appears in the output register
// in the cycle after the byte that completes it is taken; header capture,
// pixel assembly and conversion are combinational. When the receiver stalls
// with a result waiting, byte_stall rises in the same cycle and stays high
// until the result is taken; nothing is dropped. Reset sets pixel_mode to
// colour and starts a new file at the next byte. The user writes pixel_mode
// over the APB port only while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
module bmp24_pixel_stream_reader (
  input  logic        clk,
  input  logic        rst,
  // Byte input channel
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        file_start,
  // Pixel output channel
  output logic        pixel_valid,
  input  logic        pixel_stall,
  output logic [1:0]  status,
  output logic [23:0] pixel_index,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  level,
  output logic        last_pixel,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DW = bmp24_pkg::DIM_W;

  // Registers
  bmp24_pkg::mode_t  pixel_mode;
  bmp24_pkg::phase_t phase, phase_next;
  logic [31:0]   byte_pos, byte_pos_next;
  logic [31:0]   data_offset, data_offset_next;
  logic [15:0]   width_lo, width_lo_next;
  logic          width_hi_nz, width_hi_nz_next;
  logic [15:0]   height_lo, height_lo_next;
  logic          height_hi_nz, height_hi_nz_next;
  logic [15:0]   bit_depth, bit_depth_next;
  logic [DW-1:0] col_cnt, col_cnt_next;
  logic [DW-1:0] row_cnt, row_cnt_next;
  logic [23:0]   row_base, row_base_next;
  logic [1:0]    triple_ph, triple_ph_next;
  logic [7:0]    held_blue, held_blue_next;
  logic [7:0]    held_green, held_green_next;
  logic [1:0]    pad_ph, pad_ph_next;

  // Current state, with a file start taking effect before the byte is used.
  bmp24_pkg::phase_t cur_phase;
  logic [31:0]   cur_pos, cur_offset;
  logic [15:0]   cur_width_lo, cur_height_lo, cur_depth;
  logic          cur_width_hi_nz, cur_height_hi_nz;
  logic [DW-1:0] cur_col, cur_row;
  logic [23:0]   cur_base;
  logic [1:0]    cur_triple, cur_pad;
  logic [7:0]    cur_blue, cur_green;

  logic          accept, cfg_write;
  logic          hdr_end, depth_bad, too_large, empty_img, offset_big;
  logic          skip_wait, pix_act, px_complete, is_last, row_end;
  logic [DW-1:0] w_dim, h_dim;
  logic [23:0]   base_prod;
  logic          emit;
  bmp24_pkg::status_t   emit_status;
  bmp24_pkg::pixel_out_t conv_px;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == 1'(bmp24_pkg::REG_PIXEL_MODE)) ?
                     {30'd0, pixel_mode} : 32'd0;

  // The input may move whenever the output register is free or draining.
  assign byte_stall = pixel_valid && pixel_stall;
  assign accept     = byte_valid && !byte_stall;

  assign cur_phase        = file_start ? bmp24_pkg::PH_HEADER : phase;
  assign cur_pos          = file_start ? '0 : byte_pos;
  assign cur_offset       = file_start ? '0 : data_offset;
  assign cur_width_lo     = file_start ? '0 : width_lo;
  assign cur_width_hi_nz  = file_start ? 1'b0 : width_hi_nz;
  assign cur_height_lo    = file_start ? '0 : height_lo;
  assign cur_height_hi_nz = file_start ? 1'b0 : height_hi_nz;
  assign cur_depth        = file_start ? '0 : bit_depth;
  assign cur_col          = file_start ? '0 : col_cnt;
  assign cur_row          = file_start ? '0 : row_cnt;
  assign cur_base         = file_start ? '0 : row_base;
  assign cur_triple       = file_start ? '0 : triple_ph;
  assign cur_pad          = file_start ? '0 : pad_ph;
  assign cur_blue         = file_start ? '0 : held_blue;
  assign cur_green        = file_start ? '0 : held_green;

  assign w_dim = cur_width_lo[DW-1:0];
  assign h_dim = cur_height_lo[DW-1:0];

  // Header checks, applied on the last header byte.
  assign hdr_end    = (cur_phase == bmp24_pkg::PH_HEADER) &&
                      (cur_pos == 32'(bmp24_pkg::HDR_LEN - 1));
  assign depth_bad  = cur_depth != 16'(bmp24_pkg::DEPTH_24);
  assign too_large  = cur_width_hi_nz || (cur_width_lo > 16'(bmp24_pkg::MAX_DIM)) ||
                      cur_height_hi_nz || (cur_height_lo > 16'(bmp24_pkg::MAX_DIM));
  assign empty_img  = (cur_width_lo == '0) || (cur_height_lo == '0);
  assign offset_big = cur_offset > 32'(bmp24_pkg::HDR_LEN);
  assign base_prod  = 24'(h_dim - DW'(1)) * 24'(w_dim);

  // Pixel assembly.
  assign skip_wait   = (cur_phase == bmp24_pkg::PH_SKIP) && (cur_pos < cur_offset);
  assign pix_act     = (cur_phase == bmp24_pkg::PH_PIXELS) ||
                       ((cur_phase == bmp24_pkg::PH_SKIP) && !skip_wait);
  assign px_complete = pix_act && (cur_pad == 2'd0) && (cur_triple == 2'd2);
  assign row_end     = ({1'b0, cur_col} + (DW+1)'(1)) == {1'b0, w_dim};
  assign is_last     = px_complete && row_end &&
                       (({1'b0, cur_row} + (DW+1)'(1)) == {1'b0, h_dim});

  bmp24_pixel_conv u_conv (
    .mode     (pixel_mode),
    .red_in   (data_byte),
    .green_in (cur_green),
    .blue_in  (cur_blue),
    .pixel    (conv_px)
  );

  // Parse phase transitions.
  always_comb begin
    phase_next = cur_phase;
    unique case (cur_phase)
      bmp24_pkg::PH_HEADER: begin
        if (hdr_end) begin
          if (depth_bad || too_large || empty_img) begin
            phase_next = bmp24_pkg::PH_DONE;
          end else if (offset_big) begin
            phase_next = bmp24_pkg::PH_SKIP;
          end else begin
            phase_next = bmp24_pkg::PH_PIXELS;
          end
        end
      end
      bmp24_pkg::PH_SKIP: begin
        if (!skip_wait) begin
          phase_next = is_last ? bmp24_pkg::PH_DONE : bmp24_pkg::PH_PIXELS;
        end
      end
      bmp24_pkg::PH_PIXELS: begin
        if (is_last) begin
          phase_next = bmp24_pkg::PH_DONE;
        end
      end
      bmp24_pkg::PH_DONE: begin
        phase_next = bmp24_pkg::PH_DONE;
      end
      default: begin
        phase_next = bmp24_pkg::PH_DONE;
      end
    endcase
  end

  // Header capture, counters and the result.
  always_comb begin
    byte_pos_next     = cur_pos;
    data_offset_next  = cur_offset;
    width_lo_next     = cur_width_lo;
    width_hi_nz_next  = cur_width_hi_nz;
    height_lo_next    = cur_height_lo;
    height_hi_nz_next = cur_height_hi_nz;
    bit_depth_next    = cur_depth;
    col_cnt_next      = cur_col;
    row_cnt_next      = cur_row;
    row_base_next     = cur_base;
    triple_ph_next    = cur_triple;
    held_blue_next    = cur_blue;
    held_green_next   = cur_green;
    pad_ph_next       = cur_pad;
    emit              = 1'b0;
    emit_status       = bmp24_pkg::ST_PIXEL;

    if (cur_phase == bmp24_pkg::PH_HEADER) begin
      byte_pos_next = cur_pos + 32'd1;
      for (int k = 0; k < 4; k++) begin
        if (cur_pos == 32'(bmp24_pkg::OFS_POS + k)) begin
          data_offset_next[8*k +: 8] = data_byte;
        end
      end
      for (int k = 0; k < 2; k++) begin
        if (cur_pos == 32'(bmp24_pkg::WID_POS + k)) begin
          width_lo_next[8*k +: 8] = data_byte;
        end
        if (cur_pos == 32'(bmp24_pkg::WID_POS + 2 + k) && data_byte != 8'd0) begin
          width_hi_nz_next = 1'b1;
        end
        if (cur_pos == 32'(bmp24_pkg::HGT_POS + k)) begin
          height_lo_next[8*k +: 8] = data_byte;
        end
        if (cur_pos == 32'(bmp24_pkg::HGT_POS + 2 + k) && data_byte != 8'd0) begin
          height_hi_nz_next = 1'b1;
        end
        if (cur_pos == 32'(bmp24_pkg::DEP_POS + k)) begin
          bit_depth_next[8*k +: 8] = data_byte;
        end
      end
      if (hdr_end) begin
        if (depth_bad) begin
          emit        = 1'b1;
          emit_status = bmp24_pkg::ST_BAD_DEPTH;
        end else if (too_large) begin
          emit        = 1'b1;
          emit_status = bmp24_pkg::ST_TOO_LARGE;
        end else begin
          row_base_next = base_prod;
        end
      end
    end else if (skip_wait) begin
      byte_pos_next = cur_pos + 32'd1;
    end else if (pix_act) begin
      if (cur_pad != 2'd0) begin
        pad_ph_next = cur_pad - 2'd1;
      end else begin
        unique case (cur_triple)
          2'd0: begin
            held_blue_next = data_byte;
            triple_ph_next = 2'd1;
          end
          2'd1: begin
            held_green_next = data_byte;
            triple_ph_next  = 2'd2;
          end
          default: begin
            triple_ph_next = 2'd0;
            emit           = 1'b1;
            if (!is_last) begin
              if (row_end) begin
                col_cnt_next  = '0;
                row_cnt_next  = cur_row + DW'(1);
                row_base_next = cur_base - 24'(w_dim);
                pad_ph_next   = 2'(w_dim);
              end else begin
                col_cnt_next = cur_col + DW'(1);
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode   <= bmp24_pkg::MODE_COLOR;
      phase        <= bmp24_pkg::PH_HEADER;
      byte_pos     <= '0;
      data_offset  <= '0;
      width_lo     <= '0;
      width_hi_nz  <= 1'b0;
      height_lo    <= '0;
      height_hi_nz <= 1'b0;
      bit_depth    <= '0;
      col_cnt      <= '0;
      row_cnt      <= '0;
      row_base     <= '0;
      triple_ph    <= '0;
      held_blue    <= '0;
      held_green   <= '0;
      pad_ph       <= '0;
      pixel_valid  <= 1'b0;
    end else begin
      if (cfg_write && paddr[2] == 1'(bmp24_pkg::REG_PIXEL_MODE)) begin
        pixel_mode <= bmp24_pkg::mode_t'(pwdata[1:0]);
      end
      if (accept) begin
        phase        <= phase_next;
        byte_pos     <= byte_pos_next;
        data_offset  <= data_offset_next;
        width_lo     <= width_lo_next;
        width_hi_nz  <= width_hi_nz_next;
        height_lo    <= height_lo_next;
        height_hi_nz <= height_hi_nz_next;
        bit_depth    <= bit_depth_next;
        col_cnt      <= col_cnt_next;
        row_cnt      <= row_cnt_next;
        row_base     <= row_base_next;
        triple_ph    <= triple_ph_next;
        held_blue    <= held_blue_next;
        held_green   <= held_green_next;
        pad_ph       <= pad_ph_next;
        pixel_valid  <= emit;
      end else if (!pixel_stall) begin
        pixel_valid <= 1'b0;
      end
    end
  end

  // Result payload; error beats carry zero in every field but status.
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      status <= emit_status;
      if (emit_status == bmp24_pkg::ST_PIXEL) begin
        pixel_index <= cur_base + 24'(cur_col);
        red         <= conv_px.red;
        green       <= conv_px.green;
        blue        <= conv_px.blue;
        level       <= conv_px.level;
        last_pixel  <= is_last;
      end else begin
        pixel_index <= '0;
        red         <= '0;
        green       <= '0;
        blue        <= '0;
        level       <= '0;
        last_pixel  <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/bmp24_checker.sv
// ----------------------------------------------------------------------------
// bmp24_checker
// Port-level checks for the bitmap pixel stream reader, bound to its top.
// ----------------------------------------------------------------------------
module bmp24_checker (
  input logic        clk,
  input logic        rst,
  input logic        byte_stall,
  input logic        pixel_valid,
  input logic        pixel_stall,
  input logic [1:0]  status,
  input logic [23:0] pixel_index,
  input logic [7:0]  red,
  input logic [7:0]  green,
  input logic [7:0]  blue,
  input logic [7:0]  level,
  input logic        last_pixel
);

  // A waiting result holds the byte side back.
  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |-> byte_stall)
    else $error("byte side not stalled while a result waits");

  // A stalled beat stays and keeps its index, status and level.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_index) &&
    $stable(status) && $stable(level))
    else $error("stalled result beat changed");

  // Error beats carry nothing but their status.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && status != bmp24_pkg::ST_PIXEL |-> pixel_index == 24'd0 &&
    red == 8'd0 && green == 8'd0 && blue == 8'd0 && level == 8'd0 && !last_pixel)
    else $error("error beat carries pixel data");

  // Gray or black/white output never mixes with colour components.
  a_level_alone: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && level != 8'd0 |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
    else $error("level and colour both set");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> status <= bmp24_pkg::ST_TOO_LARGE)
    else $error("undefined status code");

endmodule

bind bmp24_pixel_stream_reader bmp24_checker u_bmp24_checker (.*);

// File: bench/bmp24_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_pixel_checker
// Watches the byte, pixel and APB channels of the bitmap reader. Every byte
// taken by the reader runs through a local decoder that tracks the header,
// skip and pixel phases. Each pixel or error beat it predicts is queued, and
// each beat the reader gives is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module bmp24_pixel_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        file_start,
  input  logic        pixel_valid,
  input  logic        pixel_stall,
  input  logic [1:0]  status,
  input  logic [23:0] pixel_index,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  level,
  input  logic        last_pixel,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          pixel_beats,
  output int          error_beats
);

  typedef struct {
    bmp24_pkg::status_t st;
    logic [23:0]        idx;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic [7:0]         lv;
    logic               last;
  } pixel_beat_t;

  pixel_beat_t pixels_due[$];
  pixel_beat_t oldest;

  bmp24_pkg::mode_t            cur_mode;
  bmp24_pkg::phase_t           phase;
  logic [31:0]                 pos;
  logic [31:0]                 ofs;
  logic [31:0]                 wid;
  logic [31:0]                 hgt;
  logic [15:0]                 depth;
  logic [bmp24_pkg::DIM_W-1:0] col;
  logic [bmp24_pkg::DIM_W-1:0] row;
  logic [23:0]                 base;
  logic [1:0]                  comp_n;
  logic [15:0]                 held_bg;
  logic [1:0]                  pad_left;

  task automatic clear_parse();
    phase    = bmp24_pkg::PH_HEADER;
    pos      = '0;
    ofs      = '0;
    wid      = '0;
    hgt      = '0;
    depth    = '0;
    col      = '0;
    row      = '0;
    base     = '0;
    comp_n   = '0;
    held_bg  = '0;
    pad_left = '0;
  endtask

  task automatic push_error(input bmp24_pkg::status_t st);
    pixel_beat_t pb;
    pb = '{st: st, idx: '0, r: '0, g: '0, b: '0, lv: '0, last: 1'b0};
    pixels_due.push_back(pb);
    phase = bmp24_pkg::PH_DONE;
  endtask

  task automatic take_header_byte(input logic [7:0] d);
    logic [31:0] p;
    p = pos;
    if (p >= bmp24_pkg::OFS_POS && p < bmp24_pkg::OFS_POS + 4)
      ofs[8*(p-bmp24_pkg::OFS_POS) +: 8] = d;
    else if (p >= bmp24_pkg::WID_POS && p < bmp24_pkg::WID_POS + 4)
      wid[8*(p-bmp24_pkg::WID_POS) +: 8] = d;
    else if (p >= bmp24_pkg::HGT_POS && p < bmp24_pkg::HGT_POS + 4)
      hgt[8*(p-bmp24_pkg::HGT_POS) +: 8] = d;
    else if (p >= bmp24_pkg::DEP_POS && p < bmp24_pkg::DEP_POS + 2)
      depth[8*(p-bmp24_pkg::DEP_POS) +: 8] = d;
    pos = p + 1;
    if (p != bmp24_pkg::HDR_LEN - 1)
      return;
    // Depth is checked ahead of the size limits; sizes compare as unsigned.
    if (depth != bmp24_pkg::DEPTH_24)
      push_error(bmp24_pkg::ST_BAD_DEPTH);
    else if (wid > 32'(bmp24_pkg::MAX_DIM) || hgt > 32'(bmp24_pkg::MAX_DIM))
      push_error(bmp24_pkg::ST_TOO_LARGE);
    else if (wid == 0 || hgt == 0)
      phase = bmp24_pkg::PH_DONE;
    else begin
      base  = 24'((hgt - 1) * wid);
      phase = (ofs > bmp24_pkg::HDR_LEN) ? bmp24_pkg::PH_SKIP : bmp24_pkg::PH_PIXELS;
    end
  endtask

  task automatic take_pixel_byte(input logic [7:0] d);
    pixel_beat_t pb;
    logic [9:0]  sum;
    logic [7:0]  gray;
    if (pad_left != 0) begin
      pad_left--;
      return;
    end
    if (comp_n == 0) begin
      held_bg = {8'h00, d};
      comp_n  = 2'd1;
      return;
    end
    if (comp_n == 1) begin
      held_bg[15:8] = d;
      comp_n        = 2'd2;
      return;
    end
    comp_n = 2'd0;
    sum    = 10'(held_bg[7:0]) + 10'(held_bg[15:8]) + 10'(d);
    gray   = 8'(sum / 3);
    pb = '{st: bmp24_pkg::ST_PIXEL, idx: base + 24'(col), r: '0, g: '0, b: '0,
           lv: '0, last: (32'(row) + 1 == hgt) && (32'(col) + 1 == wid)};
    unique case (cur_mode)
      bmp24_pkg::MODE_COLOR: begin
        pb.r = d;
        pb.g = held_bg[15:8];
        pb.b = held_bg[7:0];
      end
      bmp24_pkg::MODE_GRAY: pb.lv = gray;
      default:              pb.lv = (gray > bmp24_pkg::BW_THRESH) ? 8'd1 : 8'd0;
    endcase
    pixels_due.push_back(pb);
    if (pb.last) begin
      phase = bmp24_pkg::PH_DONE;
      return;
    end
    col++;
    if (32'(col) == wid) begin
      col      = '0;
      row++;
      base     = base - wid[23:0];
      pad_left = wid[1:0];
    end
  endtask

  task automatic absorb_byte(input logic [7:0] d, input logic fs);
    if (fs)
      clear_parse();
    unique case (phase)
      bmp24_pkg::PH_HEADER: take_header_byte(d);
      bmp24_pkg::PH_SKIP: begin
        if (pos < ofs)
          pos++;
        else begin
          phase = bmp24_pkg::PH_PIXELS;
          take_pixel_byte(d);
        end
      end
      bmp24_pkg::PH_PIXELS: take_pixel_byte(d);
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      $error("pixel beat field %s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cur_mode = bmp24_pkg::MODE_COLOR;
      clear_parse();
      pixels_due.delete();
      fail_count  = 0;
      pixel_beats = 0;
      error_beats = 0;
    end else begin
      // A result is registered after its byte is taken, so the pixel side goes first.
      if (pixel_valid && !pixel_stall) begin
        if (pixels_due.size() == 0) begin
          $error("pixel beat with nothing due: status %0d index %0d", status, pixel_index);
          fail_count++;
        end else begin
          oldest = pixels_due.pop_front();
          check_field("status", oldest.st, status);
          check_field("pixel_index", oldest.idx, pixel_index);
          check_field("red", oldest.r, red);
          check_field("green", oldest.g, green);
          check_field("blue", oldest.b, blue);
          check_field("level", oldest.lv, level);
          check_field("last_pixel", oldest.last, last_pixel);
          if (oldest.st == bmp24_pkg::ST_PIXEL)
            pixel_beats++;
          else
            error_beats++;
        end
      end
      // A byte taken at this edge still sees the mode from before the write.
      if (byte_valid && !byte_stall)
        absorb_byte(data_byte, file_start);
      if (psel && penable && pwrite && pready &&
          paddr == 3'(4*bmp24_pkg::REG_PIXEL_MODE))
        cur_mode = bmp24_pkg::mode_t'(pwdata[1:0]);
    end
    pending = pixels_due.size();
  end

endmodule

// File: bench/tb_bmp24_pixel_stream_reader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bmp24_pixel_stream_reader
// Feeds bitmap files byte by byte into the reader: directed files for each
// pixel mode, header errors, empty images, offsets and the largest sizes,
// then random files, broken files and noise. Both channels idle at random;
// the checker beside the reader predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_bmp24_pixel_stream_reader;

  localparam int CYCLE_LIMIT = 100_000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_BYTES = 60;

  logic        clk;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  logic [7:0]  data_byte;
  logic        file_start;
  logic        pixel_valid;
  logic        pixel_stall = 1'b0;
  logic [1:0]  status;
  logic [23:0] pixel_index;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  level;
  logic        last_pixel;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int pixel_beats;
  int error_beats;

  int          cycle_count = 0;
  int          bytes_sent = 0;
  int          hold_asked = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  bit          quiet = 1'b0;
  logic [23:0] pix_pool[$];

  bmp24_pixel_stream_reader u_top (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .data_byte   (data_byte),
    .file_start  (file_start),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .status      (status),
    .pixel_index (pixel_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .level       (level),
    .last_pixel  (last_pixel),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  bmp24_pixel_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .data_byte   (data_byte),
    .file_start  (file_start),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .status      (status),
    .pixel_index (pixel_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .level       (level),
    .last_pixel  (last_pixel),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .fail_count  (fail_count),
    .pending     (pending),
    .pixel_beats (pixel_beats),
    .error_beats (error_beats)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Pixel receiver. A requested hold-off keeps the stall up long enough for
  // the reader to back up onto its byte input.
  always @(negedge clk) begin
    if (rst)
      pixel_stall <= 1'b0;
    else if (hold_left > 0) begin
      hold_left--;
      pixel_stall <= 1'b1;
    end else if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
      pixel_stall <= 1'b1;
    end else
      pixel_stall <= !quiet && ($urandom_range(99) < 23);
  end

  // Called and returns at a falling edge; valid only drops on a gap.
  task automatic put_byte(input logic [7:0] d, input logic fs);
    if (!quiet)
      while ($urandom_range(99) < 23) begin
        byte_valid = 1'b0;
        @(negedge clk);
      end
    byte_valid = 1'b1;
    data_byte  = d;
    file_start = fs;
    @(posedge clk);
    while (byte_stall)
      @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic settle_reader();
    byte_valid = 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mode(input bmp24_pkg::mode_t m);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = 3'(4*bmp24_pkg::REG_PIXEL_MODE);
    pwdata  = {30'($urandom()), m};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Builds one file and sends its first keep bytes (all of them when keep is
  // negative). Pixels come from pix_pool while it holds any, else at random.
  task automatic send_bmp(input logic [31:0] w, h, input logic [15:0] dep,
                          input logic [31:0] ofs, input int trail, keep,
                          input logic fs);
    logic [7:0]  img[$];
    logic [7:0]  v;
    logic [23:0] px;
    int          stop;
    for (int p = 0; p < bmp24_pkg::HDR_LEN; p++) begin
      v = 8'($urandom());
      if (p >= bmp24_pkg::OFS_POS && p < bmp24_pkg::OFS_POS + 4)
        v = ofs[8*(p-bmp24_pkg::OFS_POS) +: 8];
      else if (p >= bmp24_pkg::WID_POS && p < bmp24_pkg::WID_POS + 4)
        v = w[8*(p-bmp24_pkg::WID_POS) +: 8];
      else if (p >= bmp24_pkg::HGT_POS && p < bmp24_pkg::HGT_POS + 4)
        v = h[8*(p-bmp24_pkg::HGT_POS) +: 8];
      else if (p >= bmp24_pkg::DEP_POS && p < bmp24_pkg::DEP_POS + 2)
        v = dep[8*(p-bmp24_pkg::DEP_POS) +: 8];
      img.push_back(v);
    end
    for (int p = bmp24_pkg::HDR_LEN; p < int'(ofs); p++)
      img.push_back(8'($urandom()));
    if (dep == bmp24_pkg::DEPTH_24 && w <= 32'(bmp24_pkg::MAX_DIM) &&
        h <= 32'(bmp24_pkg::MAX_DIM))
      for (int y = 0; y < int'(h); y++) begin
        for (int x = 0; x < int'(w); x++) begin
          px = (pix_pool.size() != 0) ? pix_pool.pop_front() : 24'($urandom());
          img.push_back(px[7:0]);
          img.push_back(px[15:8]);
          img.push_back(px[23:16]);
        end
        for (int k = 0; k < int'(w[1:0]); k++)
          img.push_back(8'($urandom()));
      end
    for (int k = 0; k < trail; k++)
      img.push_back(8'($urandom()));
    stop = (keep >= 0 && keep < img.size()) ? keep : img.size();
    for (int i = 0; i < stop; i++)
      put_byte(img[i], fs && i == 0);
  endtask

  task automatic random_round();
    int          kind;
    int          keep;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] ofs;
    logic [15:0] dep;
    kind = $urandom_range(99);
    if ($urandom_range(99) < 25) begin
      settle_reader();
      write_mode(bmp24_pkg::mode_t'($urandom_range(3)));
    end else if ($urandom_range(99) < 8)
      settle_reader();
    if ($urandom_range(99) < 8)
      hold_asked++;
    if (kind < 70) begin
      w    = $urandom_range(1, 7);
      h    = $urandom_range(1, 4);
      ofs  = $urandom_range(1) ? $urandom_range(0, bmp24_pkg::HDR_LEN) :
                                 $urandom_range(bmp24_pkg::HDR_LEN + 1, 70);
      // Some files are cut short, in the header, the offset gap or among the pixels.
      keep = ($urandom_range(99) < 15) ? $urandom_range(1, 100) : -1;
      send_bmp(w, h, bmp24_pkg::DEPTH_24, ofs, $urandom_range(0, 4), keep, 1'b1);
    end else if (kind < 85) begin
      dep = $urandom_range(1) ? 16'($urandom()) : 16'(bmp24_pkg::DEPTH_24);
      w   = $urandom_range(1) ? $urandom() : $urandom_range(0, 8);
      h   = $urandom_range(1) ? $urandom() : $urandom_range(0, 8);
      send_bmp(w, h, dep, $urandom_range(0, 60), $urandom_range(0, 6), -1, 1'b1);
    end else begin
      keep = $urandom_range(1, 30);
      for (int i = 0; i < keep; i++)
        put_byte(8'($urandom()), (i == 0) ? 1'($urandom_range(1)) : 1'b0);
    end
  endtask

  initial begin
    int random_start;
    byte_valid = 1'b0;
    data_byte  = '0;
    file_start = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    rst        = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // First file arrives without a file start, in colour mode from reset,
    // with an offset below the header length.
    pix_pool = {24'h000000, 24'hFFFFFF, 24'h7F7F7F, 24'h808080};
    send_bmp(2, 2, bmp24_pkg::DEPTH_24, 0, 1, -1, 1'b0);
    settle_reader();
    write_mode(bmp24_pkg::MODE_GRAY);
    pix_pool = {24'h000000, 24'hFFFFFF, 24'h7F7F7F, 24'h80807F, 24'h808080, 24'h010203};
    send_bmp(3, 2, bmp24_pkg::DEPTH_24, bmp24_pkg::HDR_LEN, 0, -1, 1'b1);
    settle_reader();
    write_mode(bmp24_pkg::MODE_BW);
    pix_pool = {24'h000000, 24'hFFFFFF, 24'h7F7F7F, 24'h80807F, 24'h808080, 24'h818080};
    send_bmp(3, 2, bmp24_pkg::DEPTH_24, bmp24_pkg::HDR_LEN + 1, 0, -1, 1'b1);
    settle_reader();
    write_mode(bmp24_pkg::MODE_BW_ALT);
    pix_pool = {24'h7F7F7F, 24'h808080, 24'hFFFFFF, 24'h000000};
    send_bmp(2, 3, bmp24_pkg::DEPTH_24, bmp24_pkg::HDR_LEN + 4, 1, -1, 1'b1);
    settle_reader();
    write_mode(bmp24_pkg::MODE_COLOR);

    // Header errors and empty images with no idling on either side; the
    // trailing bytes must be ignored.
    quiet = 1'b1;
    send_bmp(bmp24_pkg::MAX_DIM + 1, 1, bmp24_pkg::DEPTH_24, bmp24_pkg::HDR_LEN,
             2, -1, 1'b1);
    send_bmp(1, 32'hFFFF_FFFE, bmp24_pkg::DEPTH_24, bmp24_pkg::HDR_LEN, 2, -1, 1'b1);
    send_bmp(9000, 9000, 8, bmp24_pkg::HDR_LEN, 2, -1, 1'b1);
    send_bmp(0, 5, bmp24_pkg::DEPTH_24, bmp24_pkg::HDR_LEN, 2, -1, 1'b1);
    send_bmp(3, 0, bmp24_pkg::DEPTH_24, bmp24_pkg::HDR_LEN, 2, -1, 1'b1);

    // Opening pixels of a file at the largest width.
    send_bmp(bmp24_pkg::MAX_DIM, 2, bmp24_pkg::DEPTH_24, bmp24_pkg::HDR_LEN, 0,
             bmp24_pkg::HDR_LEN + 9, 1'b1);
    quiet = 1'b0;

    // Opening pixels at the largest height while the receiver holds off and
    // the input backs up.
    hold_asked++;
    send_bmp(1, bmp24_pkg::MAX_DIM, bmp24_pkg::DEPTH_24, bmp24_pkg::HDR_LEN, 0,
             bmp24_pkg::HDR_LEN + 12, 1'b1);
    settle_reader();

    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES)
      random_round();

    byte_valid = 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d file bytes; checked %0d pixel beats and %0d header error beats.",
             bytes_sent, pixel_beats, error_beats);
    $display("Covered all pixel modes, skips, empty and oversize images, cut files.");
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
rtl/bmp24_pkg.sv
rtl/bmp24_pixel_conv.sv
rtl/bmp24_pixel_stream_reader.sv
rtl/bmp24_checker.sv
bench/bmp24_pixel_checker.sv
bench/tb_bmp24_pixel_stream_reader.sv
